// ===== hw/rtl/qdpr_pkg.sv =====
// ----------------------------------------------------------------------------
// qdpr_pkg
// Shared types and constants for the quantized dot product and requantize unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qdpr_pkg;

  // Register index map of the configuration port
  localparam logic [2:0] REG_WEIGHT_ZP     = 3'd0;
  localparam logic [2:0] REG_ACTIVATION_ZP = 3'd1;
  localparam logic [2:0] REG_OUTPUT_ZP     = 3'd2;
  localparam logic [2:0] REG_SCALE_MULT    = 3'd3;
  localparam logic [2:0] REG_SCALE_SHIFT   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Reset values
  localparam logic [31:0] SCALE_MULT_RESET = 32'h4000_0000;

  // Requantization constants
  localparam logic signed [63:0] HIGH_MUL_NUDGE = 64'sh0000_0000_4000_0000;
  localparam logic signed [31:0] INT32_MIN      = 32'sh8000_0000;
  localparam logic signed [31:0] INT32_MAX      = 32'sh7FFF_FFFF;
  localparam logic [7:0]         BYTE_MAX       = 8'hFF;

  // Default depth of the queue between accumulator and requantizer
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration seen by the front and back parts
  typedef struct packed {
    logic [7:0]         weight_zp;
    logic [7:0]         activation_zp;
    logic [7:0]         output_zp;
    logic signed [31:0] scale_mult;
    logic [4:0]         scale_shift;
  } qdpr_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/quantized_dot_product_requantize_unit.sv =====
// ----------------------------------------------------------------------------
// quantized_dot_product_requantize_unit
// Quantized dot product with fixed-point requantization to an output byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one word per cycle carrying weight,
//   activation, bias and last. Each word adds (weight - wzp) * (activation -
//   azp) to a 32-bit wrapping accumulator; a word with last set also adds
//   bias and closes the dot product. Words are taken at one per cycle while
//   the sum queue has room.
//   Output channel (out_valid/out_ready): one result byte per dot product,
//   valid once its sum has passed the sum queue, the 32x32 multiply stage,
//   the high-half stage and the shift/clamp into the output register. The
//   requantizer takes one sum per cycle while out_ready is high.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while no dot product is in flight. Unknown indexes are ignored.
//   Reset: accumulator, queue and pipeline empty; zero points and shift are 0,
//   multiplier is 2^30.
//   Stall: while out_ready is low the result holds, the pipeline and the sum
//   queue fill, and then in_ready drops until space frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quantized_dot_product_requantize_unit
  import qdpr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             weight,
  input  wire logic [7:0]             activation,
  input  wire logic signed [31:0]     bias,
  input  wire logic                   last,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  result
);

  qdpr_cfg_t   cfg;
  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  logic [31:0] push_data;
  logic [31:0] pop_data;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight_zp     <= '0;
      cfg.activation_zp <= '0;
      cfg.output_zp     <= '0;
      cfg.scale_mult    <= SCALE_MULT_RESET;
      cfg.scale_shift   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WEIGHT_ZP:     cfg.weight_zp     <= cfg_data[7:0];
        REG_ACTIVATION_ZP: cfg.activation_zp <= cfg_data[7:0];
        REG_OUTPUT_ZP:     cfg.output_zp     <= cfg_data[7:0];
        REG_SCALE_MULT:    cfg.scale_mult    <= cfg_data;
        REG_SCALE_SHIFT:   cfg.scale_shift   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  qdpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .weight     (weight),
    .activation (activation),
    .bias       (bias),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  qdpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  qdpr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/qdpr_front.sv =====
// ----------------------------------------------------------------------------
// qdpr_front
// Accepts operand words, accumulates zero-point corrected products and pushes
// the biased sum into the queue on the last word of each dot product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdpr_front
  import qdpr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire qdpr_cfg_t          cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         weight,
  input  wire logic [7:0]         activation,
  input  wire logic signed [31:0] bias,
  input  wire logic               last,
  input  wire logic               q_full,
  output logic                    push,
  output logic [31:0]             push_data
);

  logic [31:0]        acc;
  logic [31:0]        acc_next;
  logic signed [8:0]  w_diff;
  logic signed [8:0]  a_diff;
  logic signed [17:0] prod;
  logic [31:0]        sum;
  logic               accept;

  // Take a word whenever the queue has room for a finished sum
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Remove zero points and multiply
  assign w_diff = $signed({1'b0, weight}) - $signed({1'b0, cfg.weight_zp});
  assign a_diff = $signed({1'b0, activation}) - $signed({1'b0, cfg.activation_zp});
  assign prod   = w_diff * a_diff;
  assign sum    = acc + {{14{prod[17]}}, prod};

  // Add bias on the last word and hand the sum to the queue
  assign push      = accept && last;
  assign push_data = sum + bias;

  always_comb begin
    acc_next = acc;
    if (accept) begin
      acc_next = last ? '0 : sum;
    end
  end

  // Hold the wrapping accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    push |=> acc == '0)
    else $error("accumulator not cleared after last word");

endmodule

`default_nettype wire

// ===== hw/rtl/qdpr_queue.sv =====
// ----------------------------------------------------------------------------
// qdpr_queue
// Small register queue of biased sums between the accumulator and the
// requantizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdpr_queue
  import qdpr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [31:0] push_data,
  input  wire logic        pop,
  output logic [31:0]      pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [31:0]      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/qdpr_back.sv =====
// ----------------------------------------------------------------------------
// qdpr_back
// Requantizer: rounding doubling high multiply, rounding shift, output zero
// point and clamp, as a three-stage stallable pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qdpr_back
  import qdpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qdpr_cfg_t   cfg,
  input  wire logic        q_empty,
  input  wire logic [31:0] q_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       result
);

  // Stage A: full product
  logic               a_vld;
  logic signed [63:0] a_prod;
  logic               a_sat;
  // Stage B: high half of the doubled product
  logic               b_vld;
  logic signed [31:0] b_high;
  // Stage B to output combinational path
  logic signed [63:0] nudged;
  logic [32:0]        half;
  logic signed [32:0] rounded;
  logic signed [32:0] shifted;
  logic signed [33:0] biased;
  logic [7:0]         clamped;
  logic signed [31:0] sum_s;
  logic               adv_a;
  logic               adv_b;
  logic               adv_c;

  // Advance each stage when the one after it frees up
  assign adv_c = b_vld && (!out_valid || out_ready);
  assign adv_b = a_vld && (!b_vld || adv_c);
  assign adv_a = !q_empty && (!a_vld || adv_b);
  assign pop   = adv_a;

  assign sum_s = q_data;

  // Nudge by 2^30 and take bits 62:31; this rounds to nearest, ties upward
  assign nudged = a_prod + HIGH_MUL_NUDGE;

  // Round half up, then floor shift
  always_comb begin
    half = '0;
    if (cfg.scale_shift != '0) begin
      half = 33'd1 << (cfg.scale_shift - 5'd1);
    end
  end
  assign rounded = {b_high[31], b_high} + $signed(half);
  assign shifted = rounded >>> cfg.scale_shift;
  assign biased  = {shifted[32], shifted} + $signed({26'd0, cfg.output_zp});

  // Clamp the full value to a byte
  always_comb begin
    if (biased[33]) begin
      clamped = '0;
    end else if (biased[32:8] != '0) begin
      clamped = BYTE_MAX;
    end else begin
      clamped = biased[7:0];
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_prod <= cfg.scale_mult * sum_s;
      a_sat  <= (cfg.scale_mult == INT32_MIN) && (sum_s == INT32_MIN);
    end
    if (adv_b) begin
      b_high <= a_sat ? INT32_MAX : nudged[62:31];
    end
    if (adv_c) begin
      result <= clamped;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) begin
        a_vld <= 1'b1;
      end else if (adv_b) begin
        a_vld <= 1'b0;
      end
      if (adv_b) begin
        b_vld <= 1'b1;
      end else if (adv_c) begin
        b_vld <= 1'b0;
      end
      if (adv_c) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sat_product: assert property (@(posedge clk) disable iff (rst)
    (a_vld && a_sat) |-> (a_prod == 64'sh4000_0000_0000_0000))
    else $error("saturation flag without minimum operands");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    adv_b |=> b_vld)
    else $error("middle stage lost a word");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: quantized dot product requantize unit
// Streams weight/activation words through the unit and compares every output
// byte with a fixed-point model or a hand-checked byte. A short table covers
// extremes, then random phases retune registers and send random dot products.
// ----------------------------------------------------------------------------

module testbench;
  import qdpr_pkg::*;

  localparam int IDLE_MAX     = 13;
  localparam int STALL_LIMIT  = 2000;
  localparam int WORD_TARGET  = 950;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_CAP   = 40;
  localparam longint Q31_ONE  = 64'sd2147483648;

  // Indexes the unit does not decode; writes to them must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [7:0]             wt;
    logic [7:0]             act;
    logic [31:0]            bias_word;
    logic                   closes;
    bit                     pinned;
    logic [7:0]             pinned_byte;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0]  reg_data;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [7:0]             weight     = '0;
  logic [7:0]             activation = '0;
  logic signed [31:0]     bias       = '0;
  logic                   last       = 1'b0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [7:0]             result;

  // Hand-checked byte that travels with the current word, if any
  logic                   pin_en     = 1'b0;
  logic [7:0]             pin_byte   = '0;

  // Model copy of the unit's registers and accumulator
  logic [31:0]            acc_model   = '0;
  logic [7:0]             wzp_model   = '0;
  logic [7:0]             azp_model   = '0;
  logic [7:0]             ozp_model   = '0;
  logic signed [31:0]     mult_model  = SCALE_MULT_RESET;
  logic [4:0]             shift_model = '0;

  logic [7:0]             pending_bytes[$];
  stim_row_t              directed_rows[$];

  int in_idle_max  = 0;
  int out_idle_max = 0;
  int words_taken  = 0;
  int products_done = 0;
  int unclamped    = 0;
  int reg_writes   = 0;
  int phases       = 0;
  int errors       = 0;
  int quiet_cycles = 0;

  quantized_dot_product_requantize_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .weight     (weight),
    .activation (activation),
    .bias       (bias),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Rounding doubling high multiply, rounding shift, offset and clamp
  function automatic logic [7:0] requantize(logic signed [31:0] total);
    longint prod;
    longint scaled;
    if (mult_model == INT32_MIN && total == INT32_MIN) begin
      scaled = longint'(INT32_MAX);
    end else begin
      prod = longint'(mult_model) * longint'(total);
      if (prod >= 0) begin
        scaled = (prod + longint'(HIGH_MUL_NUDGE)) / Q31_ONE;
      end else begin
        scaled = (prod + 64'sd1 - longint'(HIGH_MUL_NUDGE)) / Q31_ONE;
      end
    end
    if (shift_model != 5'd0) begin
      scaled = scaled + (longint'(1) << (shift_model - 1));
    end
    scaled = (scaled >>> shift_model) + longint'(ozp_model);
    if (scaled < 0) begin
      return 8'd0;
    end
    if (scaled > longint'(BYTE_MAX)) begin
      return BYTE_MAX;
    end
    return scaled[7:0];
  endfunction

  // Fold one word into the accumulator; close the dot product on last
  function automatic bit fold_word(logic [7:0] wt, logic [7:0] act, logic [31:0] b,
                                   logic closes, output logic [7:0] byte_out);
    int dw;
    int da;
    dw = int'(wt) - int'(wzp_model);
    da = int'(act) - int'(azp_model);
    acc_model = acc_model + 32'(dw * da);
    byte_out = 8'd0;
    if (!closes) begin
      return 1'b0;
    end
    acc_model = acc_model + b;
    byte_out = requantize(acc_model);
    acc_model = '0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WEIGHT_ZP:     wzp_model   = data[7:0];
      REG_ACTIVATION_ZP: azp_model   = data[7:0];
      REG_OUTPUT_ZP:     ozp_model   = data[7:0];
      REG_SCALE_MULT:    mult_model  = data;
      REG_SCALE_SHIFT:   shift_model = data[4:0];
      default: ;
    endcase
  endfunction

  function automatic int draw_wait(int max_gap);
    return (max_gap == 0) ? 0 : int'($urandom_range(max_gap, 0));
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3, 0))
      0:       return 8'd0;
      1:       return BYTE_MAX;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_bias();
    case ($urandom_range(5, 0))
      0:       return 32'd0;
      1:       return INT32_MIN;
      2:       return INT32_MAX;
      3:       return $urandom;
      default: return 32'(int'($urandom_range(8191, 0)) - 4096);
    endcase
  endfunction

  function automatic stim_row_t word_row(logic [7:0] wt, logic [7:0] act, logic [31:0] b,
                                         logic closes, bit pinned, logic [7:0] golden);
    stim_row_t row;
    row = '{ROW_WORD, wt, act, b, closes, pinned, golden, '0, '0};
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{ROW_REG, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0, 8'd0, idx, data};
    return row;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= REPORT_CAP) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
  endtask

  // Present one word after a random gap and hold it until taken
  task automatic push_word(logic [7:0] wt, logic [7:0] act, logic [31:0] b,
                           logic closes, bit pinned, logic [7:0] golden);
    int gap;
    gap = draw_wait(in_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    weight     <= wt;
    activation <= act;
    bias       <= b;
    last       <= closes;
    pin_en     <= pinned;
    pin_byte   <= golden;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop the input word, wait for every result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result side: random stall before each byte, then take it
  initial begin
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = draw_wait(out_idle_max);
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Track register writes and words, check each result byte
  always @(posedge clk) begin
    logic [7:0] predicted;
    logic [7:0] want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("result %0d with no dot product pending", result));
        end else begin
          want = pending_bytes.pop_front();
          products_done++;
          if (want != 8'd0 && want != BYTE_MAX) begin
            unclamped++;
          end
          if (result !== want) begin
            report_mismatch($sformatf("result %0d, expected %0d", result, want));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if (in_valid && in_ready) begin
        words_taken++;
        if (fold_word(weight, activation, bias, last, predicted)) begin
          pending_bytes.push_back(pin_en ? pin_byte : predicted);
        end
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[quantized_dot_product_requantize_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int n_products;
    int len;

    // Reset settings: zero points 0, multiplier 2^30, shift 0
    directed_rows.push_back(word_row(8'd0,   8'd0,   32'd0,     1'b1, 1'b1, 8'd0));
    directed_rows.push_back(word_row(8'd255, 8'd255, 32'd0,     1'b1, 1'b1, 8'd255));
    directed_rows.push_back(word_row(8'd2,   8'd3,   32'd0,     1'b1, 1'b1, 8'd3));
    directed_rows.push_back(word_row(8'd0,   8'd0,   -100,      1'b1, 1'b1, 8'd0));
    directed_rows.push_back(word_row(8'd10,  8'd10,  32'd0,     1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd10,  8'd10,  32'd0,     1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd1,   8'd1,   32'd7,     1'b1, 1'b1, 8'd104));
    // Most negative multiplier: min times min saturates, wrap into min
    directed_rows.push_back(reg_row(REG_SCALE_MULT, INT32_MIN));
    directed_rows.push_back(word_row(8'd0,   8'd0,   INT32_MIN, 1'b1, 1'b1, 8'd255));
    directed_rows.push_back(word_row(8'd1,   8'd1,   32'd0,     1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd0,   8'd0,   INT32_MAX, 1'b1, 1'b1, 8'd255));
    directed_rows.push_back(word_row(8'd0,   8'd0,   32'd1,     1'b1, 1'b1, 8'd0));
    // Every register at its top value
    directed_rows.push_back(reg_row(REG_WEIGHT_ZP,     32'd255));
    directed_rows.push_back(reg_row(REG_ACTIVATION_ZP, 32'd255));
    directed_rows.push_back(reg_row(REG_OUTPUT_ZP,     32'd255));
    directed_rows.push_back(reg_row(REG_SCALE_MULT,    INT32_MAX));
    directed_rows.push_back(reg_row(REG_SCALE_SHIFT,   32'd31));
    directed_rows.push_back(word_row(8'd0,   8'd0,   32'd0,     1'b1, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd255, 8'd255, INT32_MIN, 1'b1, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd0,   8'd255, 32'd0,     1'b1, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd128, 8'd1,   -1,        1'b1, 1'b0, 8'd0));
    // Upper data bits must be dropped; spare indexes must be ignored
    directed_rows.push_back(reg_row(REG_WEIGHT_ZP,     32'hFFFF_FF80));
    directed_rows.push_back(reg_row(REG_ACTIVATION_ZP, 32'h1234_567F));
    directed_rows.push_back(reg_row(REG_OUTPUT_ZP,     32'h0000_0080));
    directed_rows.push_back(reg_row(REG_SCALE_MULT,    32'h5A5A_5A5A));
    directed_rows.push_back(reg_row(REG_SCALE_SHIFT,   32'hFFFF_FFE1));
    directed_rows.push_back(reg_row(REG_SPARE_LO,      32'hFFFF_FFFF));
    directed_rows.push_back(reg_row(REG_SPARE_HI,      32'hA5A5_A5A5));
    directed_rows.push_back(word_row(8'd255, 8'd0,   32'd0,     1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd0,   8'd255, 32'd0,     1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd128, 8'd127, 32'd0,     1'b1, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd77,  8'd200, -12345,    1'b1, 1'b0, 8'd0));
    // Negative multiplier with a mid-range shift
    directed_rows.push_back(reg_row(REG_SCALE_SHIFT,   32'hFFFF_FFEF));
    directed_rows.push_back(reg_row(REG_SCALE_MULT,    32'hC000_0000));
    directed_rows.push_back(word_row(8'd255, 8'd255, 32'd0,     1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd0,   8'd0,   32'd1000000, 1'b0, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd200, 8'd13,  32'd65536, 1'b1, 1'b0, 8'd0));
    directed_rows.push_back(word_row(8'd1,   8'd254, -7,        1'b1, 1'b0, 8'd0));
    // Zero multiplier leaves only the output zero point
    directed_rows.push_back(reg_row(REG_SCALE_SHIFT,   32'd0));
    directed_rows.push_back(reg_row(REG_SCALE_MULT,    32'd0));
    directed_rows.push_back(word_row(8'd9,   8'd9,   32'd5,     1'b1, 1'b0, 8'd0));

    // Hold reset at the start, then release it
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed table
    in_idle_max  = IDLE_MAX;
    out_idle_max = IDLE_MAX;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (in_valid) begin
          settle();
        end
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
      end else begin
        push_word(directed_rows[i].wt, directed_rows[i].act, directed_rows[i].bias_word,
                  directed_rows[i].closes, directed_rows[i].pinned,
                  directed_rows[i].pinned_byte);
      end
    end

    // Random phases: sometimes retune while idle, then stream whole dot products
    while (words_taken < WORD_TARGET) begin
      phases++;
      settle();
      if (phases == 1 || $urandom_range(1, 0) == 1) begin
        write_reg(REG_WEIGHT_ZP,     {24'($urandom), pick_byte()});
        write_reg(REG_ACTIVATION_ZP, {24'($urandom), pick_byte()});
        write_reg(REG_OUTPUT_ZP,     {24'($urandom), pick_byte()});
        case ($urandom_range(5, 0))
          0:       write_reg(REG_SCALE_MULT, INT32_MIN);
          1:       write_reg(REG_SCALE_MULT, INT32_MAX);
          2:       write_reg(REG_SCALE_MULT, $urandom);
          default: write_reg(REG_SCALE_MULT, {2'b01, 30'($urandom)});
        endcase
        case ($urandom_range(4, 0))
          0:       write_reg(REG_SCALE_SHIFT, {27'($urandom), 5'd0});
          1:       write_reg(REG_SCALE_SHIFT, {27'($urandom), 5'd31});
          default: write_reg(REG_SCALE_SHIFT, $urandom);
        endcase
        if ($urandom_range(7, 0) == 0) begin
          write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom);
        end
      end
      in_idle_max  = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
      out_idle_max = ($urandom_range(2, 0) == 0) ? 0 : IDLE_MAX;
      n_products = $urandom_range(10, 1);
      repeat (n_products) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 17) : $urandom_range(8, 1);
        for (int k = 0; k < len; k++) begin
          if (k == len - 1) begin
            push_word(8'($urandom), 8'($urandom), pick_bias(), 1'b1, 1'b0, 8'd0);
          end else begin
            push_word(8'($urandom), 8'($urandom), $urandom, 1'b0, 1'b0, 8'd0);
          end
        end
      end
    end

    // Drain and report
    settle();
    if (pending_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_bytes.size()));
    end
    $display("Covered %0d words in %0d dot products (%0d unclamped), %0d register writes,",
             words_taken, products_done, unclamped, reg_writes);
    $display("%0d random phases, %0d mismatches.", phases, errors);
    if (errors == 0) begin
      $display("[quantized_dot_product_requantize_unit] OK");
    end else begin
      $display("[quantized_dot_product_requantize_unit] ERROR");
    end
    $finish;
  end

endmodule
